### rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU cache
// Sizes, cell command and status words, victim candidate and controller states.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int DEPTH  = 16;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 32;
  localparam int CAP_W  = 5;
  localparam int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W  = $clog2(DEPTH + 1);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_TOUCH,
    CMD_INSERT
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_VSEL,
    S_APPLY
  } state_e;

  // Command broadcast to every cell
  typedef struct packed {
    cmd_e              kind;
    logic [RANK_W-1:0] ref_rank;
    logic              wr_value;
    logic              new_entry;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  // Eviction candidate handed down the chain
  typedef struct packed {
    logic              vld;
    logic [CNT_W-1:0]  cnt;
    logic [RANK_W-1:0] rank;
    logic [KEY_W-1:0]  key;
  } cand_t;

  // Status a cell reports to the controller
  typedef struct packed {
    logic              valid;
    logic              match;
    logic [RANK_W-1:0] rank;
    logic [VAL_W-1:0]  value;
  } cell_stat_t;

endpackage

### rtl/lfu_cell.sv
// ----------------------------------------------------------------------------
// lfu_cell: one cache entry of the chain
// Holds key, value, use count and recency rank; compares against the probe
// key and passes the better eviction candidate to its right neighbor.
// ----------------------------------------------------------------------------
module lfu_cell
  import lfu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [KEY_W-1:0] probe_i,
  input  cmd_t             cmd_i,
  input  logic             fill_i,
  input  cand_t            cand_i,
  output cand_t            cand_o,
  output cell_stat_t       stat_o
);

  logic              valid_q, valid_d;
  logic              match_q, match_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  cand_t             cand_q, cand_d;
  logic              better;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      cand_q  <= '0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
      cand_q  <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    cnt_q   <= cnt_d;
    rank_q  <= rank_d;
  end

  assign match_d = valid_q && (key_q == probe_i);

  // Keep the entry with lower count, or older rank on equal count
  assign better = valid_q && (!cand_i.vld || (cnt_q < cand_i.cnt) ||
                  ((cnt_q == cand_i.cnt) && (rank_q > cand_i.rank)));

  always_comb begin
    if (better) begin
      cand_d.vld  = 1'b1;
      cand_d.cnt  = cnt_q;
      cand_d.rank = rank_q;
      cand_d.key  = key_q;
    end else begin
      cand_d = cand_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    cnt_d   = cnt_q;
    rank_d  = rank_q;
    case (cmd_i.kind)
      CMD_TOUCH: begin
        if (match_q) begin
          rank_d = '0;
          if (cmd_i.new_entry) begin
            key_d   = cmd_i.key;
            value_d = cmd_i.value;
            cnt_d   = CNT_W'(1);
          end else begin
            if (cmd_i.wr_value) begin
              value_d = cmd_i.value;
            end
            if (cnt_q != '1) begin
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
        end else if (valid_q && (rank_q < cmd_i.ref_rank)) begin
          rank_d = rank_q + RANK_W'(1);
        end
      end
      CMD_INSERT: begin
        if (fill_i) begin
          valid_d = 1'b1;
          key_d   = cmd_i.key;
          value_d = cmd_i.value;
          cnt_d   = CNT_W'(1);
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + RANK_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign cand_o       = cand_q;
  assign stat_o.valid = valid_q;
  assign stat_o.match = match_q;
  assign stat_o.rank  = rank_q;
  assign stat_o.value = value_q;

endmodule

### rtl/lfu_cache_with_lru_tiebreak.sv
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_tiebreak: LFU key-value cache, least recent use breaks ties
// Sequence: a get, a put hit or a put with room is settled in S_DECIDE, then
//   shown on the done_o strobe; a put that must evict passes S_SEARCH, S_VSEL
//   and S_APPLY first, the candidate chain settling one cell per cycle.
// Flow: words are taken only while idle; the receiver cannot stall.
// Reset: all entries invalid, occupancy zero, capacity 16; no clearing pass.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak
  import lfu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // command channel
  input  logic             start,
  output logic             busy,
  input  logic             operation_i,
  input  logic [KEY_W-1:0] lookup_key_i,
  input  logic [VAL_W-1:0] write_value_i,
  // result strobe
  output logic             done_o,
  output logic             hit_o,
  output logic [VAL_W-1:0] read_value_o,
  output logic             evicted_o,
  output logic [KEY_W-1:0] evicted_key_o,
  // capacity register write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  state_e            state_q, state_d;
  logic [CAP_W-1:0]  cap_q;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [RANK_W-1:0] cnt_q, cnt_d;
  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [KEY_W-1:0]  probe_q, probe_d;
  logic [KEY_W-1:0]  probe;

  logic              done_q, done_d;
  logic              hit_q, hit_d;
  logic [VAL_W-1:0]  rd_q, rd_d;
  logic              ev_q, ev_d;
  logic [KEY_W-1:0]  evkey_q, evkey_d;

  cmd_t              cmd;
  cand_t             cand_w [DEPTH+1];
  cell_stat_t        stat [DEPTH];
  logic [DEPTH-1:0]  valid_vec, match_vec, free_vec, fill_vec;
  logic              any_hit;
  logic [RANK_W-1:0] sel_rank;
  logic [VAL_W-1:0]  sel_value;
  logic [OCC_W-1:0]  cap_eff;
  logic              accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  // Probe follows the input key while idle so lookup happens on the accept edge
  assign probe = (state_q == S_IDLE) ? lookup_key_i : probe_q;

  // --------------------------------------------------------------------------
  // Cell chain: candidates enter on the left with nothing valid
  // --------------------------------------------------------------------------
  assign cand_w[0] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    lfu_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .probe_i(probe),
      .cmd_i  (cmd),
      .fill_i (fill_vec[g]),
      .cand_i (cand_w[g]),
      .cand_o (cand_w[g+1]),
      .stat_o (stat[g])
    );
    assign valid_vec[g] = stat[g].valid;
    assign match_vec[g] = stat[g].match;
  end

  // Keys are unique among valid entries, so the match vector is one-hot or empty
  always_comb begin
    sel_rank  = '0;
    sel_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_vec[i]) begin
        sel_rank  = sel_rank | stat[i].rank;
        sel_value = sel_value | stat[i].value;
      end
    end
  end

  assign any_hit  = |match_vec;
  assign free_vec = ~valid_vec;
  // Lowest free entry: isolate the lowest set bit
  assign fill_vec = free_vec & (~free_vec + DEPTH'(1));

  // Capacity above DEPTH acts as DEPTH
  assign cap_eff = (int'(cap_q) > DEPTH) ? OCC_W'(DEPTH) : OCC_W'(cap_q);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= CAP_W'(16);
      occ_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      key_q <= lookup_key_i;
      val_q <= write_value_i;
    end
    probe_q <= probe_d;
    hit_q   <= hit_d;
    rd_q    <= rd_d;
    ev_q    <= ev_d;
    evkey_q <= evkey_d;
  end

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    occ_d         = occ_q;
    cnt_d         = cnt_q;
    probe_d       = probe_q;
    done_d        = 1'b0;
    hit_d         = hit_q;
    rd_d          = rd_q;
    ev_d          = ev_q;
    evkey_d       = evkey_q;
    cmd.kind      = CMD_NONE;
    cmd.ref_rank  = sel_rank;
    cmd.wr_value  = 1'b0;
    cmd.new_entry = 1'b0;
    cmd.key       = key_q;
    cmd.value     = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          probe_d = lookup_key_i;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // Default finish: report and return to idle
        hit_d   = any_hit;
        ev_d    = 1'b0;
        evkey_d = '0;
        rd_d    = '0;
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (op_q == OP_GET) begin
          if (any_hit) begin
            rd_d     = sel_value;
            cmd.kind = CMD_TOUCH;
          end else begin
            rd_d = '1;
          end
        end else if (cap_eff != '0) begin
          if (any_hit) begin
            cmd.kind     = CMD_TOUCH;
            cmd.wr_value = 1'b1;
          end else if (occ_q < cap_eff) begin
            cmd.kind = CMD_INSERT;
            occ_d    = occ_q + OCC_W'(1);
          end else begin
            // Full: hold off reporting until the victim is replaced
            done_d  = 1'b0;
            cnt_d   = '0;
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // Let the candidate ripple through every cell
        cnt_d = cnt_q + RANK_W'(1);
        if (cnt_q == RANK_W'(DEPTH - 1)) begin
          probe_d = cand_w[DEPTH].key;
          state_d = S_VSEL;
        end
      end
      S_VSEL: begin
        // Cells latch the match against the victim key
        state_d = S_APPLY;
      end
      S_APPLY: begin
        // Replace the victim in place; ranks shift as for a touch of it
        cmd.kind      = CMD_TOUCH;
        cmd.new_entry = 1'b1;
        hit_d         = 1'b0;
        rd_d          = '0;
        ev_d          = 1'b1;
        evkey_d       = probe_q;
        done_d        = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign read_value_o  = rd_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = evkey_q;

endmodule

### rtl/lfu_chk.sv
// ----------------------------------------------------------------------------
// lfu_chk: port-level checks for the LFU cache
// Watches the command, result and busy ports over time.
// ----------------------------------------------------------------------------
module lfu_chk
  import lfu_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic             hit_o,
  input logic [VAL_W-1:0] read_value_o,
  input logic             evicted_o,
  input logic [KEY_W-1:0] evicted_key_o
);

  // A result word appears as the block drops back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted word keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // Each word gives one single-cycle result
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held two cycles");

  // An eviction only comes from a put of an absent key
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_o) |-> (!hit_o && (read_value_o == '0)))
    else $error("eviction reported with hit or read data");

  // No eviction, no evicted key
  a_evkey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !evicted_o) |-> (evicted_key_o == '0))
    else $error("evicted key nonzero without eviction");

endmodule

bind lfu_cache_with_lru_tiebreak lfu_chk u_lfu_chk (.*);
